/* src/bpc_pkg.sv */
// bpc_pkg: types and constants shared by the button press classifier.
// Holds the field widths, register indexes, phase enum and the
// configuration and event structs. No dependencies.
package bpc_pkg;

    localparam int LEVEL_W   = 4;   // width of levels and of each event field
    localparam int CFG_IDX_W = 3;   // config register index
    localparam int CFG_DAT_W = 16;  // config write data
    localparam int STEP_W    = 8;
    localparam int TIME_W    = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_TIME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIME    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME     = 3'd4;

    // reset values
    localparam logic [LEVEL_W-1:0] RST_ACTIVE_LEVELS = 4'd0;
    localparam logic [STEP_W-1:0]  RST_TICK_STEP     = 8'd5;
    localparam logic [TIME_W-1:0]  RST_FILTER_TIME   = 16'd20;
    localparam logic [TIME_W-1:0]  RST_SHORT_TIME    = 16'd100;
    localparam logic [TIME_W-1:0]  RST_LONG_TIME     = 16'd1000;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_HELD     = 2'd2,
        PH_LONGHELD = 2'd3
    } t_phase;

    typedef struct packed {
        logic [LEVEL_W-1:0] active_levels;
        logic [STEP_W-1:0]  tick_step;
        logic [TIME_W-1:0]  filter_time;
        logic [TIME_W-1:0]  short_time;
        logic [TIME_W-1:0]  long_time;
    } t_cfg;

    typedef struct packed {
        logic short_press;
        logic long_press;
    } t_lane_evt;

endpackage

/* src/bpc_if.sv */
// bpc_if: valid/ready channel interfaces for ticks, event words and
// configuration writes. Depends on bpc_pkg for field widths.
interface bpc_in_if;
    logic                        valid;
    logic                        ready;
    logic [bpc_pkg::LEVEL_W-1:0] levels;

    modport source (output valid, output levels, input ready);
    modport sink   (input valid, input levels, output ready);
endinterface

interface bpc_out_if;
    logic                        valid;
    logic                        ready;
    logic [bpc_pkg::LEVEL_W-1:0] short_events;
    logic [bpc_pkg::LEVEL_W-1:0] long_events;

    modport source (output valid, output short_events, output long_events, input ready);
    modport sink   (input valid, input short_events, input long_events, output ready);
endinterface

interface bpc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bpc_pkg::CFG_IDX_W-1:0] index;
    logic [bpc_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/bpc_lane.sv */
// bpc_lane: one button's phase machine and saturating press counter.
// Depends on bpc_pkg.
module bpc_lane #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick,
    input  logic                 i_active,
    input  bpc_pkg::t_cfg        i_cfg,
    output bpc_pkg::t_lane_evt   o_evt
);
    import bpc_pkg::*;

    localparam int SUM_W = COUNT_WIDTH + 1;
    localparam int CMP_W = (COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [SUM_W-1:0]       sum;
    logic [COUNT_WIDTH-1:0] sat_sum;
    logic                   sum_ge_short, sum_ge_long, cnt_ge_filter;

    assign sum     = {1'b0, r_count} + SUM_W'(i_cfg.tick_step);
    assign sat_sum = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];

    assign sum_ge_short  = CMP_W'(sat_sum) >= CMP_W'(i_cfg.short_time);
    assign sum_ge_long   = CMP_W'(sat_sum) >= CMP_W'(i_cfg.long_time);
    assign cnt_ge_filter = CMP_W'(r_count) >= CMP_W'(i_cfg.filter_time);

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_RELEASED: begin
                if (i_active) n_phase = PH_PRESSED;
            end
            PH_PRESSED: begin
                if (!i_active)         n_phase = PH_RELEASED;
                else if (sum_ge_short) n_phase = PH_HELD;
            end
            PH_HELD: begin
                if (!i_active)        n_phase = PH_RELEASED;
                else if (sum_ge_long) n_phase = PH_LONGHELD;
            end
            PH_LONGHELD: begin
                if (!i_active) n_phase = PH_RELEASED;
            end
            default: n_phase = PH_RELEASED;
        endcase
    end

    // counter and events
    always_comb begin
        n_count           = r_count;
        o_evt.short_press = 1'b0;
        o_evt.long_press  = 1'b0;
        if (!i_active) begin
            n_count = '0;
        end else if (r_phase != PH_LONGHELD) begin
            n_count = sat_sum;   // frozen once long-held
        end
        o_evt.short_press = (r_phase == PH_PRESSED) && !i_active && cnt_ge_filter;
        o_evt.long_press  = (r_phase == PH_HELD) && i_active && sum_ge_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RELEASED;
            r_count <= '0;
        end else if (i_tick) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

endmodule

/* src/bpc_merge.sv */
// bpc_merge: gathers the lane events into one word and queues it in a
// two-entry output buffer. Depends on bpc_pkg and bpc_if.
module bpc_merge #(
    parameter int NUM_BUTTONS = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    input  bpc_pkg::t_lane_evt [NUM_BUTTONS-1:0]   i_evt,
    output logic                                   o_can_push,
    bpc_out_if.source                              o_evt
);
    import bpc_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0] shorts;
        logic [LEVEL_W-1:0] longs;
    } t_word;

    t_word       packed_word;
    t_word       r_buf [2];
    logic        r_wptr, r_rptr;
    logic [1:0]  r_count;
    logic        pop;

    // lanes beyond the field width are dropped, missing lanes read zero
    for (genvar b = 0; b < LEVEL_W; b++) begin : g_pack
        if (b < NUM_BUTTONS) begin : g_lane
            assign packed_word.shorts[b] = i_evt[b].short_press;
            assign packed_word.longs[b]  = i_evt[b].long_press;
        end else begin : g_none
            assign packed_word.shorts[b] = 1'b0;
            assign packed_word.longs[b]  = 1'b0;
        end
    end

    assign o_can_push         = (r_count != 2'd2);
    assign pop                = o_evt.valid && o_evt.ready;
    assign o_evt.valid        = (r_count != 2'd0);
    assign o_evt.short_events = r_buf[r_rptr].shorts;
    assign o_evt.long_events  = r_buf[r_rptr].longs;

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wptr] <= packed_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (pop)    r_rptr <= ~r_rptr;
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/button_press_classifier.sv */
// button_press_classifier: top level. Configuration registers, one lane per
// button and the merging output queue. Depends on bpc_pkg, bpc_if,
// bpc_lane and bpc_merge.
//
// Classifies button presses from periodic ticks. Each tick word carries the
// sampled level of every button; a button is active when its level equals its
// bit in active_levels. Every button has its own lane: a released / pressed /
// held / long-held machine plus a press counter that adds tick_step per
// active tick and saturates at 2^COUNT_WIDTH - 1. A short press is flagged
// when a button is let go in the pressed phase with at least filter_time on
// the counter; a long press is flagged once, on the tick at which a held
// button reaches long_time. Every accepted tick yields exactly one event word
// (short_events, long_events), usually all zeros. Throughput is one tick per
// clock: all lanes update in parallel in the accept cycle (one add and three
// compares per lane), and the event word is queued behind any older word.
// A two-entry output queue lets one more tick in while a word waits;
// ticks stall only when both entries are full. Config writes are always
// taken (ready tied high) and should only be issued while the block is idle.
// Buttons beyond the 4-bit fields see level 0 against active level 0.
module button_press_classifier #(
    parameter int NUM_BUTTONS = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpc_in_if.sink     i_tick,
    bpc_cfg_if.sink    i_cfg,
    bpc_out_if.source  o_evt
);
    import bpc_pkg::*;

    t_cfg                         r_cfg;
    logic                         tick_acc;
    logic                         can_push;
    logic [NUM_BUTTONS-1:0]       active;
    t_lane_evt [NUM_BUTTONS-1:0]  lane_evt;

    // --- configuration registers ---
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_levels <= RST_ACTIVE_LEVELS;
            r_cfg.tick_step     <= RST_TICK_STEP;
            r_cfg.filter_time   <= RST_FILTER_TIME;
            r_cfg.short_time    <= RST_SHORT_TIME;
            r_cfg.long_time     <= RST_LONG_TIME;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_ACTIVE_LEVELS: r_cfg.active_levels <= i_cfg.data[LEVEL_W-1:0];
                REG_TICK_STEP:     r_cfg.tick_step     <= i_cfg.data[STEP_W-1:0];
                REG_FILTER_TIME:   r_cfg.filter_time   <= i_cfg.data[TIME_W-1:0];
                REG_SHORT_TIME:    r_cfg.short_time    <= i_cfg.data[TIME_W-1:0];
                REG_LONG_TIME:     r_cfg.long_time     <= i_cfg.data[TIME_W-1:0];
                default:           ;   // unknown index: ignored
            endcase
        end
    end

    // --- tick handshake: take a word whenever the queue has room ---
    assign i_tick.ready = can_push;
    assign tick_acc     = i_tick.valid && i_tick.ready;

    // --- lanes ---
    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        if (b < LEVEL_W) begin : g_wired
            assign active[b] = (i_tick.levels[b] == r_cfg.active_levels[b]);
        end else begin : g_unwired
            assign active[b] = 1'b1;   // both bits read as zero
        end

        bpc_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tick   (tick_acc),
            .i_active (active[b]),
            .i_cfg    (r_cfg),
            .o_evt    (lane_evt[b])
        );
    end

    // --- merge and output queue ---
    bpc_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (tick_acc),
        .i_evt      (lane_evt),
        .o_can_push (can_push),
        .o_evt      (o_evt)
    );

    // --- assertions ---
    // a button never reports short and long in the same word
    a_no_dual_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.valid |-> ((o_evt.short_events & o_evt.long_events) == '0))
        else $error("short and long event on one button");

    // an accepted tick always leaves a word waiting on the next cycle
    a_tick_to_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tick.valid && i_tick.ready) |=> o_evt.valid)
        else $error("accepted tick produced no event word");

    // an empty queue never stalls the tick channel
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_evt.valid |-> i_tick.ready)
        else $error("tick stalled with empty output queue");

    // nothing is offered straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_evt.valid)
        else $error("event word valid after reset");

endmodule

/* test/bpc_event_checker.sv */
`timescale 1ns / 1ps
// bpc_event_checker: watches the tick, config and event channels of the
// button press classifier, predicts every event word and compares it.
// Depends on bpc_pkg.
module bpc_event_checker
    import bpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick_valid,
    input  logic                 i_tick_ready,
    input  logic [LEVEL_W-1:0]   i_tick_levels,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_evt_valid,
    input  logic                 i_evt_ready,
    input  logic [LEVEL_W-1:0]   i_evt_short,
    input  logic [LEVEL_W-1:0]   i_evt_long,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct packed {
        logic [LEVEL_W-1:0] shorts;
        logic [LEVEL_W-1:0] longs;
    } t_evt_word;

    t_cfg              shadow_cfg;
    t_phase            lane_phase [LEVEL_W];
    logic [TIME_W-1:0] lane_time  [LEVEL_W];
    t_evt_word         expected_words [$];
    int                err_count = 0;

    // Advances every lane by one tick and returns the event word it yields.
    function automatic t_evt_word classify_tick(input logic [LEVEL_W-1:0] lv);
        t_evt_word         w;
        logic              act;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] grown;
        w = '0;
        for (int b = 0; b < LEVEL_W; b++) begin
            act   = (lv[b] == shadow_cfg.active_levels[b]);
            sum   = {1'b0, lane_time[b]} + shadow_cfg.tick_step;
            grown = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            case (lane_phase[b])
                PH_RELEASED: begin
                    if (act) begin
                        lane_time[b]  = grown;
                        lane_phase[b] = PH_PRESSED;
                    end
                end
                PH_PRESSED: begin
                    if (act) begin
                        lane_time[b] = grown;
                        if (grown >= shadow_cfg.short_time) lane_phase[b] = PH_HELD;
                    end else begin
                        if (lane_time[b] >= shadow_cfg.filter_time) w.shorts[b] = 1'b1;
                        lane_phase[b] = PH_RELEASED;
                        lane_time[b]  = '0;
                    end
                end
                PH_HELD: begin
                    if (act) begin
                        lane_time[b] = grown;
                        if (grown >= shadow_cfg.long_time) begin
                            w.longs[b]    = 1'b1;
                            lane_phase[b] = PH_LONGHELD;
                        end
                    end else begin
                        lane_phase[b] = PH_RELEASED;
                        lane_time[b]  = '0;
                    end
                end
                default: begin
                    // long-held: counter frozen until let go
                    if (!act) begin
                        lane_phase[b] = PH_RELEASED;
                        lane_time[b]  = '0;
                    end
                end
            endcase
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_evt_word want;
        if (!i_rst_n) begin
            shadow_cfg.active_levels = RST_ACTIVE_LEVELS;
            shadow_cfg.tick_step     = RST_TICK_STEP;
            shadow_cfg.filter_time   = RST_FILTER_TIME;
            shadow_cfg.short_time    = RST_SHORT_TIME;
            shadow_cfg.long_time     = RST_LONG_TIME;
            for (int b = 0; b < LEVEL_W; b++) begin
                lane_phase[b] = PH_RELEASED;
                lane_time[b]  = '0;
            end
            expected_words.delete();
        end else begin
            if (i_evt_valid && i_evt_ready) begin
                if (expected_words.size() == 0) begin
                    $error("event word with none expected: short_events %h long_events %h",
                           i_evt_short, i_evt_long);
                    err_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (want.shorts !== i_evt_short) begin
                        $error("short_events: expected %h, got %h", want.shorts, i_evt_short);
                        err_count++;
                    end
                    if (want.longs !== i_evt_long) begin
                        $error("long_events: expected %h, got %h", want.longs, i_evt_long);
                        err_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ACTIVE_LEVELS: shadow_cfg.active_levels = i_cfg_data[LEVEL_W-1:0];
                    REG_TICK_STEP:     shadow_cfg.tick_step     = i_cfg_data[STEP_W-1:0];
                    REG_FILTER_TIME:   shadow_cfg.filter_time   = i_cfg_data[TIME_W-1:0];
                    REG_SHORT_TIME:    shadow_cfg.short_time    = i_cfg_data[TIME_W-1:0];
                    REG_LONG_TIME:     shadow_cfg.long_time     = i_cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (i_tick_valid && i_tick_ready)
                expected_words.push_back(classify_tick(i_tick_levels));
        end
        o_errors  <= err_count;
        o_pending <= expected_words.size();
    end

endmodule

/* test/button_press_classifier_tb.sv */
`timescale 1ns / 1ps
// button_press_classifier_tb: stimulus and verdict for the button press
// classifier. Depends on bpc_pkg, bpc_if, the block and bpc_event_checker.
module button_press_classifier_tb;
    import bpc_pkg::*;

    localparam int RUN_LIMIT    = 400000;  // cycles, far above a slow correct run
    localparam int TAIL_CYCLES  = 8;       // settle time once all words are back
    localparam int LONG_HOLD    = 150;     // receiver hold-off for the fill test
    localparam int PHASE_ITEMS  = 235;
    localparam int NUM_PHASES   = 8;
    localparam int MAX_SPAN     = 300;     // longest press run in ticks

    // first index past the register file; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_LONG_TIME + 1'b1;

    logic i_clk;
    logic i_rst_n;

    bpc_in_if  tick_if ();
    bpc_cfg_if cfg_if ();
    bpc_out_if evt_if ();

    int errors;
    int pending;
    int cycle_count = 0;

    // idling controls, read by the sender task and the receiver process
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_request       = 1'b0;
    int hold_left          = 0;

    // local copy of what has been written, to steer the stimulus
    logic [LEVEL_W-1:0] cur_active = RST_ACTIVE_LEVELS;
    logic [STEP_W-1:0]  cur_step   = RST_TICK_STEP;
    logic [TIME_W-1:0]  cur_filter = RST_FILTER_TIME;
    logic [TIME_W-1:0]  cur_short  = RST_SHORT_TIME;
    logic [TIME_W-1:0]  cur_long   = RST_LONG_TIME;

    // per-button run of active or inactive ticks in the random part
    int   run_len [LEVEL_W];
    logic run_act [LEVEL_W];

    // directed press patterns, one bit per button, 1 = pressed
    // first set: short press, too-brief tap, release from held, long press
    logic [LEVEL_W-1:0] masks_a [13] = '{
        4'b0000, 4'b1111, 4'b1111, 4'b1111, 4'b1110, 4'b1010, 4'b1010,
        4'b1010, 4'b1010, 4'b1010, 4'b0000, 4'b0001, 4'b0000
    };
    // second set, zero step and zero thresholds: counter stays put, a tap
    // still gives a short press, held and long-held follow straight away
    logic [LEVEL_W-1:0] masks_b [9] = '{
        4'b0001, 4'b0000, 4'b0010, 4'b0010, 4'b0010, 4'b0000,
        4'b1000, 4'b1000, 4'b0000
    };

    button_press_classifier u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_if),
        .i_cfg   (cfg_if),
        .o_evt   (evt_if)
    );

    bpc_event_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick_valid  (tick_if.valid),
        .i_tick_ready  (tick_if.ready),
        .i_tick_levels (tick_if.levels),
        .i_cfg_valid   (cfg_if.valid),
        .i_cfg_ready   (cfg_if.ready),
        .i_cfg_index   (cfg_if.index),
        .i_cfg_data    (cfg_if.data),
        .i_evt_valid   (evt_if.valid),
        .i_evt_ready   (evt_if.ready),
        .i_evt_short   (evt_if.short_events),
        .i_evt_long    (evt_if.long_events),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so the
    // output queue fills and the tick input backs up.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (!i_rst_n) begin
            evt_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            evt_if.ready <= 1'b0;
        end else begin
            evt_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // pressed mask to levels: pressed reads as the button's active level
    function automatic logic [LEVEL_W-1:0] levels_for(input logic [LEVEL_W-1:0] act);
        return ~(act ^ cur_active);
    endfunction

    // Offer one tick word and wait for it to be taken. Valid is left high
    // so back-to-back words need no toggle within a time step.
    task automatic send_tick(input logic [LEVEL_W-1:0] lv);
        while ($urandom_range(99) < sender_idle_pct) begin
            tick_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_if.valid  <= 1'b1;
        tick_if.levels <= lv;
        @(posedge i_clk);
        while (!tick_if.ready) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] dat);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= dat;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
    endtask

    // Drain, then write every register. Unused data bits get random junk,
    // and one write goes to an index past the register file.
    task automatic load_config(input logic [LEVEL_W-1:0] al, input logic [STEP_W-1:0] stp,
                               input logic [TIME_W-1:0] flt, input logic [TIME_W-1:0] sht,
                               input logic [TIME_W-1:0] lng);
        logic [CFG_DAT_W-1:0] junk;
        tick_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        junk = CFG_DAT_W'($urandom);
        write_reg(REG_ACTIVE_LEVELS, {junk[CFG_DAT_W-1:LEVEL_W], al});
        junk = CFG_DAT_W'($urandom);
        write_reg(REG_TICK_STEP, {junk[CFG_DAT_W-1:STEP_W], stp});
        write_reg(REG_FILTER_TIME, flt);
        write_reg(REG_SHORT_TIME, sht);
        write_reg(REG_LONG_TIME, lng);
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_UNUSED_LO), (1 << CFG_IDX_W) - 1)),
                  CFG_DAT_W'($urandom));
        cfg_if.valid <= 1'b0;
        cur_active = al;
        cur_step   = stp;
        cur_filter = flt;
        cur_short  = sht;
        cur_long   = lng;
    endtask

    // Random presses: mostly clean press runs around a threshold, split by
    // one- to four-tick releases, with some one- or two-tick chatter mixed in.
    task automatic run_random(input int n_items);
        logic [LEVEL_W-1:0] act;
        int                 thr;
        int                 span;
        for (int k = 0; k < n_items; k++) begin
            act = '0;
            for (int b = 0; b < LEVEL_W; b++) begin
                if (run_len[b] == 0) begin
                    if ($urandom_range(99) < 15) begin
                        run_act[b] = 1'($urandom_range(1));
                        run_len[b] = $urandom_range(1, 2);
                    end else begin
                        run_act[b] = !run_act[b];
                        if (!run_act[b]) begin
                            run_len[b] = $urandom_range(1, 4);
                        end else begin
                            case ($urandom_range(3))
                                0:       thr = int'(cur_filter);
                                1:       thr = int'(cur_short);
                                2:       thr = int'(cur_long);
                                default: thr = $urandom_range(int'(cur_long) + int'(cur_step));
                            endcase
                            span = thr / int'(cur_step) + $urandom_range(3) - 1;
                            if (span < 1) span = 1;
                            if (span > MAX_SPAN) span = MAX_SPAN;
                            run_len[b] = span;
                        end
                    end
                end
                run_len[b]--;
                act[b] = run_act[b];
            end
            // fill test: hold the receiver off early in each phase with no idling or stalls
            if (k == 50 && sender_idle_pct == 0 && receiver_stall_pct == 0)
                hold_request = 1'b1;
            send_tick(levels_for(act));
        end
    endtask

    initial begin
        tick_if.valid  = 1'b0;
        tick_if.levels = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = '0;
        cfg_if.data    = '0;
        evt_if.ready   = 1'b0;
        i_rst_n        = 1'b0;
        for (int b = 0; b < LEVEL_W; b++) begin
            run_len[b] = 0;
            run_act[b] = 1'b0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a couple of words under the reset configuration
        send_tick(4'hF);
        send_tick(4'h0);

        load_config(4'b0101, 8'd10, 16'd20, 16'd40, 16'd80);
        foreach (masks_a[i]) send_tick(levels_for(masks_a[i]));

        load_config(4'b1111, 8'd0, 16'd0, 16'd0, 16'd0);
        foreach (masks_b[i]) send_tick(levels_for(masks_b[i]));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: load_config(4'hF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: load_config(4'h0, 8'd1, 16'd0, 16'd0, 16'd0);
                default: load_config(LEVEL_W'($urandom_range(15)), STEP_W'($urandom_range(1, 24)),
                                     TIME_W'($urandom_range(60)), TIME_W'($urandom_range(160)),
                                     TIME_W'($urandom_range(400)));
            endcase
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
                default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
            endcase
            run_random(PHASE_ITEMS);
        end

        tick_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
src/bpc_pkg.sv
src/bpc_if.sv
src/bpc_lane.sv
src/bpc_merge.sv
src/button_press_classifier.sv
test/bpc_event_checker.sv
test/button_press_classifier_tb.sv
